// ----- rtl/core/dmx_svo_pkg.sv -----
// dmx_svo_pkg.sv: shared widths, register indexes and reset values
// for the dmx slot to servo change mapper; no dependencies
package dmx_svo_pkg;

   // field widths of the stream items
   localparam int SLOT_W      = 10;
   localparam int BYTE_W      = 8;
   localparam int BOARD_W     = 5;
   localparam int OUTCH_W     = 4;
   localparam int POS_W       = 12;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDE_MODE     = 2'd0,
      CSR_CHANNEL_COUNT = 2'd1,
      CSR_START_ADDRESS = 2'd2
   } csr_index_type;

   localparam logic [SLOT_W-1:0] RST_CHANNEL_COUNT = 10'd16;
   localparam logic [SLOT_W-1:0] RST_START_ADDRESS = 10'd1;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

endpackage

// ----- rtl/core/dmx_svo_front.sv -----
// dmx_svo_front.sv: configuration registers and slot classification
// (window test, channel and board quotient); depends on dmx_svo_pkg
module dmx_svo_front
   import dmx_svo_pkg::*;
#(
   parameter int UNIVERSE_SLOTS    = 512,
   parameter int OUTPUTS_PER_BOARD = 16,
   parameter int OFF_W             = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [SLOT_W-1:0]     slot_number,
   input  logic [BYTE_W-1:0]     slot_byte,
   output logic                  keep,
   output logic [OFF_W-1:0]      q_offset,
   output logic [BYTE_W-1:0]     q_byte,
   output logic                  q_wide,
   output logic [OFF_W-1:0]      q_channel,
   output logic [OFF_W-1:0]      q_quot
);

   // exact reciprocal for dividends below 2**OFF_W
   localparam int DIV_SH  = OFF_W + $clog2(OUTPUTS_PER_BOARD);
   localparam int RECIP   = ((1 << DIV_SH) + OUTPUTS_PER_BOARD - 1) / OUTPUTS_PER_BOARD;
   localparam int PROD_W  = 2 * OFF_W + 1;

   logic              wide_mode_ff, wide_mode_in;
   logic [SLOT_W-1:0] channel_count_ff, channel_count_in;
   logic [SLOT_W-1:0] start_address_ff, start_address_in;

   logic [SLOT_W-1:0] start;
   logic [SLOT_W:0]   footprint;
   logic [SLOT_W-1:0] offset_full;
   logic [OFF_W-1:0]  channel;
   logic [PROD_W-1:0] prod;

   always_comb begin
      wide_mode_in     = wide_mode_ff;
      channel_count_in = channel_count_ff;
      start_address_in = start_address_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDE_MODE:     wide_mode_in     = csr_data[0];
            CSR_CHANNEL_COUNT: channel_count_in = csr_data;
            CSR_START_ADDRESS: start_address_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_mode_ff     <= 1'b0;
         channel_count_ff <= RST_CHANNEL_COUNT;
         start_address_ff <= RST_START_ADDRESS;
      end else begin
         wide_mode_ff     <= wide_mode_in;
         channel_count_ff <= channel_count_in;
         start_address_ff <= start_address_in;
      end
   end

   // start address zero counts as one
   assign start       = (start_address_ff == '0) ? SLOT_W'(1) : start_address_ff;
   assign footprint   = wide_mode_ff ? {channel_count_ff, 1'b0} : {1'b0, channel_count_ff};
   assign offset_full = slot_number - start;

   assign keep = (slot_number != '0) && (slot_number >= start) &&
                 ({1'b0, offset_full} < footprint) &&
                 (offset_full < SLOT_W'(UNIVERSE_SLOTS));

   assign q_offset  = offset_full[OFF_W-1:0];
   assign q_byte    = slot_byte;
   assign q_wide    = wide_mode_ff;
   assign channel   = wide_mode_ff ? (q_offset >> 1) : q_offset;
   assign q_channel = channel;
   assign prod      = PROD_W'(channel) * PROD_W'(RECIP);
   assign q_quot    = OFF_W'(prod >> DIV_SH);

endmodule

// ----- rtl/core/dmx_svo_queue.sv -----
// dmx_svo_queue.sv: short register fifo between the classifying front
// and the store back end; no dependencies
module dmx_svo_queue #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != CNT_W'(DEPTH))
      else $error("queue pushed while full");

endmodule

// ----- rtl/core/dmx_svo_back.sv -----
// dmx_svo_back.sv: previous-byte store (even and odd banks), change
// detection, pair handling and the result register; depends on dmx_svo_pkg
module dmx_svo_back
   import dmx_svo_pkg::*;
#(
   parameter int UNIVERSE_SLOTS    = 512,
   parameter int OUTPUTS_PER_BOARD = 16,
   parameter int OFF_W             = 9
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  logic [OFF_W-1:0]   q_offset,
   input  logic [BYTE_W-1:0]  q_byte,
   input  logic               q_wide,
   input  logic [OFF_W-1:0]   q_channel,
   input  logic [OFF_W-1:0]   q_quot,
   output logic               q_pop,
   output logic               clear_busy,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BOARD_W-1:0] rsp_board,
   output logic [OUTCH_W-1:0] rsp_output_channel,
   output logic [POS_W-1:0]   rsp_position,
   output logic               rsp_is_wide
);

   localparam int BANK_AW    = OFF_W - 1;
   localparam int BANK_DEPTH = (UNIVERSE_SLOTS + 1) / 2;

   logic [BYTE_W-1:0] even_mem [BANK_DEPTH];
   logic [BYTE_W-1:0] odd_mem  [BANK_DEPTH];

   // clearing sweep after reset
   logic               clr_busy_ff, clr_busy_in;
   logic [BANK_AW-1:0] clr_addr_ff, clr_addr_in;

   // execute stage
   logic              b_valid_ff, b_valid_in;
   logic [OFF_W-1:0]  b_off_ff;
   logic [BYTE_W-1:0] b_byte_ff;
   logic              b_wide_ff;
   logic [OFF_W-1:0]  b_chan_ff;
   logic [OFF_W-1:0]  b_quot_ff;
   logic [BYTE_W-1:0] rd_even_ff, rd_odd_ff;
   logic              byp_even_ff, byp_odd_ff;
   logic [BYTE_W-1:0] byp_even_data_ff, byp_odd_data_ff;

   logic [BYTE_W-1:0] held_byte_ff, held_byte_in;
   logic              held_chg_ff, held_chg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BOARD_W-1:0] rsp_board_ff;
   logic [OUTCH_W-1:0] rsp_outch_ff;
   logic [POS_W-1:0]   rsp_position_ff;
   logic               rsp_is_wide_ff;

   logic               b_odd, low_of_pair;
   logic [BYTE_W-1:0]  prev_even, prev_odd, prev;
   logic               byte_diff, has_result, out_free, b_go, a_go;
   logic [BANK_AW-1:0] raddr, waddr;
   logic               we_even, we_odd;
   logic [BYTE_W-1:0]  wdata_even, wdata_odd;
   logic [OFF_W-1:0]   rem;
   logic [POS_W-1:0]   position;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == BANK_AW'(BANK_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   assign clear_busy = clr_busy_ff;

   assign b_odd       = b_off_ff[0];
   assign low_of_pair = b_wide_ff && b_odd;
   assign prev_even   = byp_even_ff ? byp_even_data_ff : rd_even_ff;
   assign prev_odd    = byp_odd_ff ? byp_odd_data_ff : rd_odd_ff;
   assign prev        = b_odd ? prev_odd : prev_even;
   assign byte_diff   = (b_byte_ff != prev);
   // a high byte of a pair never gives a result
   assign has_result  = b_wide_ff ? (b_odd && (held_chg_ff || byte_diff)) : byte_diff;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign b_go        = b_valid_ff && (!has_result || out_free);
   assign a_go        = q_valid && !clr_busy_ff && (!b_valid_ff || b_go);
   assign q_pop       = a_go;
   assign raddr       = q_offset[OFF_W-1:1];

   always_comb begin
      we_even    = 1'b0;
      we_odd     = 1'b0;
      waddr      = b_off_ff[OFF_W-1:1];
      wdata_even = b_byte_ff;
      wdata_odd  = b_byte_ff;
      if (clr_busy_ff) begin
         we_even    = 1'b1;
         we_odd     = 1'b1;
         waddr      = clr_addr_ff;
         wdata_even = '0;
         wdata_odd  = '0;
      end else if (b_go && has_result) begin
         if (low_of_pair) begin
            we_even    = 1'b1;
            we_odd     = 1'b1;
            wdata_even = held_byte_ff;
         end else if (b_odd) begin
            we_odd = 1'b1;
         end else begin
            we_even = 1'b1;
         end
      end
   end

   // store banks, read registered, bypass covers a write in the read cycle
   always_ff @(posedge clock) begin
      if (we_even) begin
         even_mem[waddr] <= wdata_even;
      end
      if (we_odd) begin
         odd_mem[waddr] <= wdata_odd;
      end
      if (a_go) begin
         rd_even_ff       <= even_mem[raddr];
         rd_odd_ff        <= odd_mem[raddr];
         byp_even_ff      <= we_even && (waddr == raddr);
         byp_odd_ff       <= we_odd && (waddr == raddr);
         byp_even_data_ff <= wdata_even;
         byp_odd_data_ff  <= wdata_odd;
         b_off_ff         <= q_offset;
         b_byte_ff        <= q_byte;
         b_wide_ff        <= q_wide;
         b_chan_ff        <= q_channel;
         b_quot_ff        <= q_quot;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (a_go) begin
         b_valid_in = 1'b1;
      end else if (b_go) begin
         b_valid_in = 1'b0;
      end
   end

   always_comb begin
      held_byte_in = held_byte_ff;
      held_chg_in  = held_chg_ff;
      if (b_go && b_wide_ff) begin
         if (b_odd) begin
            held_chg_in = 1'b0;
         end else begin
            held_byte_in = b_byte_ff;
            held_chg_in  = byte_diff;
         end
      end
   end

   assign rem      = OFF_W'(b_chan_ff - OFF_W'(32'(b_quot_ff) * OUTPUTS_PER_BOARD));
   assign position = low_of_pair ? ({held_byte_ff, 4'b0000} | {4'b0000, b_byte_ff})
                                 : {4'b0000, b_byte_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (b_go && has_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         b_valid_ff   <= 1'b0;
         held_byte_ff <= '0;
         held_chg_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         b_valid_ff   <= b_valid_in;
         held_byte_ff <= held_byte_in;
         held_chg_ff  <= held_chg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go && has_result) begin
         rsp_board_ff    <= BOARD_W'(b_quot_ff);
         rsp_outch_ff    <= OUTCH_W'(rem);
         rsp_position_ff <= position;
         rsp_is_wide_ff  <= b_wide_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_board          = rsp_board_ff;
   assign rsp_output_channel = rsp_outch_ff;
   assign rsp_position       = rsp_position_ff;
   assign rsp_is_wide        = rsp_is_wide_ff;

   a_no_issue_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !a_go && !b_valid_ff)
      else $error("item issued during store clearing");

   a_narrow_fits_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_is_wide_ff |-> rsp_position_ff[POS_W-1:BYTE_W] == '0)
      else $error("narrow position wider than a byte");

   a_pair_clears_flag: assert property (@(posedge clock) disable iff (reset)
      b_go && low_of_pair |=> !held_chg_ff)
      else $error("held change flag survived a low byte");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> rem < OFF_W'(OUTPUTS_PER_BOARD))
      else $error("output channel remainder out of range");

endmodule

// ----- rtl/core/dmx_slot_to_servo_change_mapper.sv -----
// dmx_slot_to_servo_change_mapper.sv: top level of the dmx slot to servo mapper
// depends on dmx_svo_pkg, dmx_svo_front, dmx_svo_queue and dmx_svo_back
//
// Takes one DMX slot per cycle while req_tready is high and emits a servo command
// when a slot byte in the configured window differs from the byte last stored for
// it (in wide mode a command per high/low pair). The front classifies each slot in
// the cycle it is accepted and drops slots outside the window; kept slots go
// through a four-entry queue to the back end, whose execute stage reads the
// previous-byte store and then compares and writes it, so a result passes the
// queue, the execute stage and the result register. Sustained rate is one slot
// per cycle while rsp_tready is high, set by the single read and write per store
// bank per cycle; the result register lets a new slot in while a command waits on
// rsp_tready. After reset the store is cleared over all (UNIVERSE_SLOTS+1)/2
// addresses of each bank (256 by default), while req_tready stays low; csr_ready is always high.
module dmx_slot_to_servo_change_mapper
   import dmx_svo_pkg::*;
#(
   parameter int UNIVERSE_SLOTS    = 512,
   parameter int OUTPUTS_PER_BOARD = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   // slot stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [9:0] slot_number, [17:10] slot_byte
   // command stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [4:0] board, [8:5] output_channel,
                                               // [20:9] position
   output logic                   rsp_tuser    // [0] is_wide
);

   localparam int OFF_W = $clog2(UNIVERSE_SLOTS);
   localparam int QW    = 3 * OFF_W + BYTE_W + 1;

   logic              keep, push, q_full, q_valid, q_pop, clear_busy;
   logic [OFF_W-1:0]  f_offset, f_channel, f_quot;
   logic [BYTE_W-1:0] f_byte;
   logic              f_wide;
   logic [QW-1:0]     push_data, pop_data;

   logic [BOARD_W-1:0] board;
   logic [OUTCH_W-1:0] output_channel;
   logic [POS_W-1:0]   position;
   logic               is_wide;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full && !clear_busy;
   assign push       = req_tvalid && req_tready && keep;

   dmx_svo_front #(
      .UNIVERSE_SLOTS    (UNIVERSE_SLOTS),
      .OUTPUTS_PER_BOARD (OUTPUTS_PER_BOARD),
      .OFF_W             (OFF_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .slot_number (req_tdata[SLOT_W-1:0]),
      .slot_byte   (req_tdata[SLOT_W+BYTE_W-1:SLOT_W]),
      .keep        (keep),
      .q_offset    (f_offset),
      .q_byte      (f_byte),
      .q_wide      (f_wide),
      .q_channel   (f_channel),
      .q_quot      (f_quot)
   );

   assign push_data = {f_quot, f_channel, f_wide, f_byte, f_offset};

   dmx_svo_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .not_empty (q_valid)
   );

   dmx_svo_back #(
      .UNIVERSE_SLOTS    (UNIVERSE_SLOTS),
      .OUTPUTS_PER_BOARD (OUTPUTS_PER_BOARD),
      .OFF_W             (OFF_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_offset           (pop_data[OFF_W-1:0]),
      .q_byte             (pop_data[OFF_W+BYTE_W-1:OFF_W]),
      .q_wide             (pop_data[OFF_W+BYTE_W]),
      .q_channel          (pop_data[2*OFF_W+BYTE_W:OFF_W+BYTE_W+1]),
      .q_quot             (pop_data[QW-1:2*OFF_W+BYTE_W+1]),
      .q_pop              (q_pop),
      .clear_busy         (clear_busy),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_board          (board),
      .rsp_output_channel (output_channel),
      .rsp_position       (position),
      .rsp_is_wide        (is_wide)
   );

   assign rsp_tdata = {3'b000, position, output_channel, board};
   assign rsp_tuser = is_wide;

endmodule
